@@ rtl/assert_macros.svh @@
// Assertion helpers for the console writer.
// TCW_ASSERT checks a condition at every clock edge outside reset.
// TCW_ASSERT_NEXT checks a consequence in the clock cycle after its trigger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TCW_ASSERT(lbl, clk_s, rstn_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) else $error(msg);
`define TCW_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCW_ASSERT(lbl, clk_s, rstn_s, expr, msg)
`define TCW_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

@@ rtl/tcw_pkg.sv @@
`default_nettype none
package tcw_pkg;

  // Default screen geometry
  localparam int SCREEN_ROWS_DEF = 25;
  localparam int SCREEN_COLS_DEF = 80;

  // Character and attribute constants
  localparam logic [7:0]  NEWLINE_CODE    = 8'h0A;
  localparam logic [7:0]  SPACE_CODE      = 8'h20;
  localparam logic [7:0]  TEXT_ATTR_RST   = 8'h0F;
  localparam logic [7:0]  BLANK_ATTR_RST  = 8'h07;
  localparam logic [4:0]  SCROLL_ROWS_RST = 5'd14;
  localparam logic [15:0] RESET_CELL      = 16'h0720;

  // Operation codes
  typedef enum logic [1:0] {
    OP_PUT_CHAR = 2'd0,
    OP_PUT_HEX  = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_TEXT_ATTR   = 2'd0,
    REG_BLANK_ATTR  = 2'd1,
    REG_SCROLL_ROWS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] text_attr;
    logic [7:0] blank_attr;
    logic [4:0] scroll_rows;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } item_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [15:0] cell_data;
  } res_t;

  localparam logic [15:0][7:0] HEX_DIGITS = {
    8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  // Upper-case ASCII digit for one nibble
  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    return HEX_DIGITS[nib];
  endfunction

endpackage
`default_nettype wire

@@ rtl/tcw_in_if.sv @@
`default_nettype none
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, op, char_code, read_row, read_col, input ready);
  modport sink (input valid, op, char_code, read_row, read_col, output ready);
endinterface
`default_nettype wire

@@ rtl/tcw_out_if.sv @@
`default_nettype none
interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic [15:0] cell_data;

  modport source (output valid, cursor_row, cursor_col, cell_data, input ready);
  modport sink (input valid, cursor_row, cursor_col, cell_data, output ready);
endinterface
`default_nettype wire

@@ rtl/tcw_screen_ram.sv @@
`default_nettype none
module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = SCREEN_ROWS_DEF * SCREEN_COLS_DEF,
  localparam int IW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic          re,
  input  wire logic [IW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
`default_nettype none
module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = SCREEN_COLS_DEF,
  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS,
  localparam int IW = $clog2(CELLS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cfg_t          cfg,
  input  wire logic          in_valid,
  input  wire item_t         in_item,
  output logic               in_ready,
  input  wire logic          out_free,
  output logic               res_load,
  output res_t               res,
  output logic               ram_we,
  output logic [IW-1:0]      ram_waddr,
  output logic [15:0]        ram_wdata,
  output logic               ram_re,
  output logic [IW-1:0]      ram_raddr,
  input  wire logic [15:0]   ram_rdata
);

  localparam int AW = $clog2(CELLS + 1);
  localparam int RW = $clog2(SCREEN_ROWS + 1);
  localparam int CW = $clog2(SCREEN_COLS);
  localparam logic [AW-1:0] COLS_A    = AW'(SCREEN_COLS);
  localparam logic [AW-1:0] CELLS_A   = AW'(CELLS);
  localparam logic [CW-1:0] LAST_COL  = CW'(SCREEN_COLS - 1);

  typedef enum logic [5:0] {
    S_FILL = 6'b000001,
    S_IDLE = 6'b000010,
    S_CHAR = 6'b000100,
    S_COPY = 6'b001000,
    S_READ = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [7:0]    char_r, char_nxt;
  logic          second_r, second_nxt;
  logic          init_r, init_nxt;
  logic          in_range_r, in_range_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] waddr_r, waddr_nxt;
  logic [15:0]   fill_val_r, fill_val_nxt;
  logic [15:0]   data_r, data_nxt;

  logic [RW-1:0] height;
  logic [7:0]    cur_char;
  logic [RW-1:0] nrow;
  logic [CW-1:0] ncol;
  logic [AW-1:0] char_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] last_ptr;
  logic [AW-1:0] waddr_a;
  logic [AW-1:0] raddr_a;
  logic [15:0]   cell_res;
  logic          rd_ok;
  logic          char_done;
  logic          do_finish;

  // Clamp the scroll height to between one row and the screen height
  always_comb begin
    if (cfg.scroll_rows == '0) begin
      height = RW'(1);
    end else if (int'(cfg.scroll_rows) > SCREEN_ROWS) begin
      height = RW'(SCREEN_ROWS);
    end else begin
      height = RW'(cfg.scroll_rows);
    end
  end

  // Shared address arithmetic
  assign cur_char  = (op_r == OP_PUT_HEX) ?
                     hex_ascii(second_r ? char_r[3:0] : char_r[7:4]) : char_r;
  assign char_addr = AW'(row_r) * COLS_A + AW'(col_r);
  assign rd_addr   = AW'(in_item.read_row) * COLS_A + AW'(in_item.read_col);
  assign rd_ok     = (int'(in_item.read_row) < SCREEN_ROWS) &&
                     (int'(in_item.read_col) < SCREEN_COLS);
  assign last_ptr  = end_r - AW'(1);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    op_nxt       = op_r;
    char_nxt     = char_r;
    second_nxt   = second_r;
    init_nxt     = init_r;
    in_range_nxt = in_range_r;
    ptr_nxt      = ptr_r;
    end_nxt      = end_r;
    pend_nxt     = pend_r;
    waddr_nxt    = waddr_r;
    fill_val_nxt = fill_val_r;
    data_nxt     = data_r;
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    waddr_a      = ptr_r;
    raddr_a      = ptr_r;
    ram_wdata    = fill_val_r;
    cell_res     = '0;
    char_done    = 1'b0;
    do_finish    = 1'b0;
    nrow         = row_r;
    ncol         = col_r;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = in_item.op;
          char_nxt   = in_item.char_code;
          second_nxt = 1'b0;
          case (in_item.op)
            OP_PUT_CHAR, OP_PUT_HEX: begin
              state_nxt = S_CHAR;
            end
            OP_CLEAR: begin
              row_nxt      = '0;
              col_nxt      = '0;
              ptr_nxt      = '0;
              end_nxt      = CELLS_A;
              fill_val_nxt = {cfg.blank_attr, SPACE_CODE};
              state_nxt    = S_FILL;
            end
            default: begin
              in_range_nxt = rd_ok;
              ram_re       = rd_ok;
              raddr_a      = rd_addr;
              state_nxt    = S_READ;
            end
          endcase
        end
      end

      S_CHAR: begin
        // Write the character unless newline, then advance, wrap or scroll
        if (cur_char == NEWLINE_CODE) begin
          nrow = row_r + RW'(1);
          ncol = '0;
        end else begin
          ram_we    = (int'(row_r) < SCREEN_ROWS) && (int'(col_r) < SCREEN_COLS);
          waddr_a   = char_addr;
          ram_wdata = {cfg.text_attr, cur_char};
          if (col_r == LAST_COL) begin
            nrow = row_r + RW'(1);
            ncol = '0;
          end else begin
            nrow = row_r;
            ncol = col_r + CW'(1);
          end
        end
        if (nrow >= height) begin
          row_nxt   = height - RW'(1);
          col_nxt   = '0;
          ptr_nxt   = COLS_A;
          end_nxt   = AW'(height) * COLS_A;
          pend_nxt  = 1'b0;
          state_nxt = S_COPY;
        end else begin
          row_nxt   = nrow;
          col_nxt   = ncol;
          char_done = 1'b1;
        end
      end

      S_COPY: begin
        // Read one cell a cycle, write it one row up in the following cycle
        ram_re    = ptr_r < end_r;
        raddr_a   = ptr_r;
        ram_we    = pend_r;
        waddr_a   = waddr_r;
        ram_wdata = ram_rdata;
        pend_nxt  = ram_re;
        if (ram_re) begin
          ptr_nxt   = ptr_r + AW'(1);
          waddr_nxt = ptr_r - COLS_A;
        end else if (!pend_r) begin
          ptr_nxt      = end_r - COLS_A;
          fill_val_nxt = {cfg.blank_attr, SPACE_CODE};
          state_nxt    = S_FILL;
        end
      end

      S_FILL: begin
        ram_we  = 1'b1;
        waddr_a = ptr_r;
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == last_ptr) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else if (op_r == OP_CLEAR) begin
            do_finish = 1'b1;
          end else begin
            char_done = 1'b1;
          end
        end
      end

      S_READ: begin
        cell_res  = in_range_r ? ram_rdata : '0;
        do_finish = 1'b1;
      end

      S_DONE: begin
        cell_res  = data_r;
        do_finish = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Second digit of a hex byte, else the item is complete
    if (char_done) begin
      if ((op_r == OP_PUT_HEX) && !second_r) begin
        second_nxt = 1'b1;
        state_nxt  = S_CHAR;
      end else begin
        do_finish = 1'b1;
      end
    end

    // Hand the result over, or hold it until the output frees up
    if (do_finish) begin
      data_nxt  = cell_res;
      state_nxt = out_free ? S_IDLE : S_DONE;
    end
  end

  assign res_load       = do_finish && out_free;
  assign res.cursor_row = 5'(row_nxt);
  assign res.cursor_col = 7'(col_nxt);
  assign res.cell_data  = cell_res;
  assign ram_waddr      = waddr_a[IW-1:0];
  assign ram_raddr      = raddr_a[IW-1:0];

  // Registers; reset starts the clearing pass over the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_FILL;
      init_r     <= 1'b1;
      row_r      <= '0;
      col_r      <= '0;
      ptr_r      <= '0;
      end_r      <= CELLS_A;
      pend_r     <= 1'b0;
      fill_val_r <= RESET_CELL;
      second_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      init_r     <= init_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      ptr_r      <= ptr_nxt;
      end_r      <= end_nxt;
      pend_r     <= pend_nxt;
      fill_val_r <= fill_val_nxt;
      second_r   <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    char_r     <= char_nxt;
    in_range_r <= in_range_nxt;
    waddr_r    <= waddr_nxt;
    data_r     <= data_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/text_console_writer.sv @@
// Text console writer: a character terminal over a screen store of 16-bit
// cells (attribute in the high byte, character in the low byte).
// Input channel in_ch carries one operation per transaction: put char,
// put hex byte, clear screen or read cell. Each transaction yields exactly
// one result transaction on out_ch with the cursor position after the
// operation and, for a read, the cell contents.
// With R rows, C columns and scroll height H, clearing the screen writes
// one cell per cycle, and a scroll copies rows 1 to H-1 up by one row
// and then blanks row H-1.
// The screen store has a single write port: the sequencer moves one cell
// per cycle through it. in_ch.ready is high only while idle.
// Reset clears the cursor, restores the configuration defaults and runs a
// clearing pass over all R*C cells that fills the store with 0x0720; no
// input is taken meanwhile, while the configuration port accepts writes.
// A stalled out_ch holds its result; the next input can be accepted and
// worked on, and its result waits until the output register frees up.
`default_nettype none
`include "assert_macros.svh"
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = SCREEN_COLS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tcw_in_if.sink           in_ch,
  tcw_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int IW = $clog2(CELLS);

  logic [7:0] text_attr_r;
  logic [7:0] blank_attr_r;
  logic [4:0] scroll_rows_r;
  cfg_t       cfg;
  item_t      item;
  res_t       res, res_r;
  logic       res_load;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r   <= TEXT_ATTR_RST;
      blank_attr_r  <= BLANK_ATTR_RST;
      scroll_rows_r <= SCROLL_ROWS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TEXT_ATTR:   text_attr_r   <= cfg_pwdata[7:0];
        REG_BLANK_ATTR:  blank_attr_r  <= cfg_pwdata[7:0];
        REG_SCROLL_ROWS: scroll_rows_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TEXT_ATTR:   cfg_prdata = {24'b0, text_attr_r};
      REG_BLANK_ATTR:  cfg_prdata = {24'b0, blank_attr_r};
      REG_SCROLL_ROWS: cfg_prdata = {27'b0, scroll_rows_r};
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.text_attr   = text_attr_r;
  assign cfg.blank_attr  = blank_attr_r;
  assign cfg.scroll_rows = scroll_rows_r;

  assign item.op        = in_ch.op;
  assign item.char_code = in_ch.char_code;
  assign item.read_row  = in_ch.read_row;
  assign item.read_col  = in_ch.read_col;

  tcw_ctrl #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_item   (item),
    .in_ready  (in_ch.ready),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcw_screen_ram #(
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: hold the result until the transaction completes
  assign out_free      = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = (out_valid_r && !out_ch.ready) || res_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_row = res_r.cursor_row;
  assign out_ch.cursor_col = res_r.cursor_col;
  assign out_ch.cell_data  = res_r.cell_data;

  // Checks
  `TCW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready,
    "input taken again right after a transaction")
  `TCW_ASSERT(a_col_range, clk, rst_n,
    !out_ch.valid || (32'(out_ch.cursor_col) < SCREEN_COLS), "cursor column beyond screen")
  `TCW_ASSERT(a_waddr_range, clk, rst_n, !ram_we || (32'(ram_waddr) < CELLS),
    "store write beyond screen")
  `TCW_ASSERT(a_no_rw_clash, clk, rst_n, !(ram_we && ram_re && (ram_waddr == ram_raddr)),
    "store read and write at one address")

endmodule
`default_nettype wire
